@@ src/assert_macros.svh @@
// Assertion macros used by the top level of the list block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SLID_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SLID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/slid_pkg.sv @@
// Package: sizes, command codes and shared types of the list block.
`timescale 1ns / 1ps
package slid_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = IDX_W + 1;

    localparam logic [1:0] KIND_FRONT  = 2'd0;
    localparam logic [1:0] KIND_BACK   = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
        logic signed [31:0] position;
    } in_t;

    typedef struct packed {
        logic signed [31:0] element;
        logic               is_last;
        logic               list_empty;
        logic               dropped;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic do_insert;
        logic set_drop;
        logic del_start;
        logic del_commit;
        logic shift_step;
        logic shift_wb;
        logic emit_step;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_insert;
        logic full;
        logic del_ok;
        logic del_tail;
        logic shift_last;
        logic emit_last;
    } sts_t;

    // Logical offset to physical slot of the circular store.
    function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= SUM_W'(CAPACITY))
            sum = sum - SUM_W'(CAPACITY);
        return sum[IDX_W-1:0];
    endfunction

endpackage

@@ src/slid_ctrl.sv @@
// Controller state machine of the list block.
`timescale 1ns / 1ps
module slid_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  slid_pkg::sts_t sts,
    output slid_pkg::cmd_t cmd,
    output logic          busy
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_EXEC     = 6'b000010,
        ST_SHIFT    = 6'b000100,
        ST_SHIFT_WB = 6'b001000,
        ST_EMIT     = 6'b010000,
        ST_FLUSH    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_EMIT;
                if (sts.is_insert)
                begin
                    if (sts.full)
                        cmd.set_drop = 1'b1;
                    else
                        cmd.do_insert = 1'b1;
                end
                else if (sts.del_ok)
                begin
                    if (sts.del_tail)
                        cmd.del_commit = 1'b1;
                    else
                    begin
                        cmd.del_start = 1'b1;
                        state_next    = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (sts.shift_last)
                    state_next = ST_SHIFT_WB;
            end
            ST_SHIFT_WB:
            begin
                cmd.shift_wb = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit_step = 1'b1;
                if (sts.emit_last)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ src/slid_datapath.sv @@
// Datapath of the list block: circular entry store, counters, result stage.
`timescale 1ns / 1ps
module slid_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  slid_pkg::in_t  command,
    input  slid_pkg::cmd_t cmd,
    output slid_pkg::sts_t sts,
    output logic           strobe,
    output slid_pkg::out_t result
);

    localparam int IW = slid_pkg::IDX_W;
    localparam int CW = slid_pkg::CNT_W;

    logic [31:0] mem [slid_pkg::CAPACITY];

    logic [1:0]         kind_reg,   kind_next;
    logic signed [31:0] value_reg,  value_next;
    logic signed [31:0] pos_reg,    pos_next;
    logic [IW-1:0]      head_reg,   head_next;
    logic [CW-1:0]      count_reg,  count_next;
    logic [IW-1:0]      rd_idx_reg, rd_idx_next;
    logic [IW-1:0]      wr_idx_reg, wr_idx_next;
    logic               wr_vld_reg, wr_vld_next;
    logic [IW-1:0]      em_idx_reg, em_idx_next;
    logic               drop_reg,   drop_next;
    logic               pend_reg,   pend_next;
    logic               plast_reg,  plast_next;
    logic               pempty_reg, pempty_next;
    logic [31:0]        rdata_reg;

    logic          wr_en, rd_en;
    logic [IW-1:0] wr_addr, rd_addr;
    logic [31:0]   wr_data;
    logic [IW-1:0] head_dec;
    logic [CW-1:0] count_m1;

    assign head_dec = (head_reg == '0) ? IW'(slid_pkg::CAPACITY - 1) : head_reg - IW'(1);
    assign count_m1 = count_reg - CW'(1);

    // status
    always_comb
    begin
        sts.is_insert  = (kind_reg == slid_pkg::KIND_FRONT) ||
                         (kind_reg == slid_pkg::KIND_BACK);
        sts.full       = (count_reg == CW'(slid_pkg::CAPACITY));
        sts.del_ok     = (kind_reg == slid_pkg::KIND_DELETE) && !pos_reg[31] &&
                         ($unsigned(pos_reg) < 32'(count_reg));
        sts.del_tail   = (($unsigned(pos_reg) + 32'd1) == 32'(count_reg));
        sts.shift_last = (CW'(rd_idx_reg) == count_m1);
        sts.emit_last  = (count_reg == '0) || (CW'(em_idx_reg) == count_m1);
    end

    // store ports
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rdata_reg;
        rd_en   = 1'b0;
        rd_addr = '0;
        if (cmd.do_insert)
        begin
            wr_en   = 1'b1;
            wr_data = value_reg;
            if (kind_reg == slid_pkg::KIND_FRONT)
                wr_addr = head_dec;
            else
                wr_addr = slid_pkg::phys_idx(head_reg, count_reg[IW-1:0]);
        end
        else if ((cmd.shift_step && wr_vld_reg) || cmd.shift_wb)
        begin
            wr_en   = 1'b1;
            wr_addr = slid_pkg::phys_idx(head_reg, wr_idx_reg);
        end
        if (cmd.shift_step)
        begin
            rd_en   = 1'b1;
            rd_addr = slid_pkg::phys_idx(head_reg, rd_idx_reg);
        end
        else if (cmd.emit_step)
        begin
            rd_en   = 1'b1;
            rd_addr = slid_pkg::phys_idx(head_reg, em_idx_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    // next state
    always_comb
    begin
        kind_next   = kind_reg;
        value_next  = value_reg;
        pos_next    = pos_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        wr_vld_next = wr_vld_reg;
        em_idx_next = em_idx_reg;
        drop_next   = drop_reg;
        pend_next   = cmd.emit_step;
        plast_next  = sts.emit_last;
        pempty_next = (count_reg == '0);

        if (cmd.load)
        begin
            kind_next   = command.kind;
            value_next  = command.value;
            pos_next    = command.position;
            drop_next   = 1'b0;
            em_idx_next = '0;
        end
        if (cmd.set_drop)
            drop_next = 1'b1;
        if (cmd.do_insert)
        begin
            count_next = count_reg + CW'(1);
            if (kind_reg == slid_pkg::KIND_FRONT)
                head_next = head_dec;
        end
        if (cmd.del_start)
        begin
            rd_idx_next = pos_reg[IW-1:0] + IW'(1);
            wr_vld_next = 1'b0;
        end
        if (cmd.shift_step)
        begin
            rd_idx_next = rd_idx_reg + IW'(1);
            wr_idx_next = rd_idx_reg - IW'(1);
            wr_vld_next = 1'b1;
        end
        if (cmd.del_commit || cmd.shift_wb)
            count_next = count_m1;
        if (cmd.emit_step)
            em_idx_next = em_idx_reg + IW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            wr_vld_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            wr_vld_reg <= wr_vld_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        value_reg  <= value_next;
        pos_reg    <= pos_next;
        rd_idx_reg <= rd_idx_next;
        wr_idx_reg <= wr_idx_next;
        em_idx_reg <= em_idx_next;
        drop_reg   <= drop_next;
        plast_reg  <= plast_next;
        pempty_reg <= pempty_next;
    end

    assign strobe            = pend_reg;
    assign result.element    = pempty_reg ? '0 : $signed(rdata_reg);
    assign result.is_last    = plast_reg;
    assign result.list_empty = pempty_reg;
    assign result.dropped    = drop_reg;

endmodule

@@ src/sequence_list_insert_delete.sv @@
// Top level of the ordered list block: controller plus datapath.
//
// Usage: present a command on 'command' and raise 'start'; the transaction
// is taken at the rising edge where start is high and busy is low. Kinds:
// insert at front, append at back, delete at a zero-based position. Kind 3
// and an out-of-range delete leave the list as it is.
// After each command the whole list is sent front to back, one transaction
// per entry on 'result', each marked by 'strobe' for exactly one cycle; the
// final one carries is_last. An empty list gives one result with list_empty
// set and element zero. An insert into a full list is refused and every
// result of that run carries dropped.
// The first result follows the accepting edge through the execute and emit
// states and the registered store read; results then come one per cycle.
// Busy stays high through the execute, emit and flush states, plus the
// shift states if a delete must close the gap: entries behind the deleted
// one move down one slot a cycle through the single read and single write
// port of the entry store, and the first result waits for them. Front
// inserts move the head pointer of the circular store and cost no shift.
// Reset clears the list to empty at once; no clearing pass is run.
// The receiver cannot stall; results must be taken as they come.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sequence_list_insert_delete (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  slid_pkg::in_t  command,
    output logic           strobe,
    output slid_pkg::out_t result
);

    slid_pkg::cmd_t cmd;
    slid_pkg::sts_t sts;

    // Sequencer: accept, execute, optional shift, read-out.
    slid_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Entry store, pointers and result stage.
    slid_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .command (command),
        .cmd     (cmd),
        .sts     (sts),
        .strobe  (strobe),
        .result  (result)
    );

    // Results only come while a command is in flight.
    `SLID_ASSERT_SAME(a_strobe_busy, strobe, busy, "result outside a command")
    // An accepted transaction keeps the block busy in the next cycle.
    `SLID_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept did not start work")
    // An empty-list result is always the only one of its run.
    `SLID_ASSERT_SAME(a_empty_last, strobe && result.list_empty, result.is_last,
        "empty result not last")
    // Nothing follows the last result of a run.
    `SLID_ASSERT_NEXT(a_last_gap, strobe && result.is_last, !strobe,
        "result after last marker")

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the sequence_list_insert_delete ordered list block.
`timescale 1ns / 1ps
module testbench;

    // Kind 3 has no package name; the block treats it as a no-op.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 200;
    localparam int QUIET_TAIL   = 40;      // last items run with no idling
    localparam int DRAIN_LIMIT  = 4000;    // cycles allowed for the last run to arrive

    // Random part is shaped in phases so the list fills up, empties and churns.
    typedef enum int {PH_GROW, PH_MIXED, PH_SHRINK} phase_t;

    // ------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the list and the queue of
    // result transactions that each accepted command is due to produce.
    // ------------------------------------------------------------------
    class list_scoreboard;
        logic signed [31:0] held[$];       // list contents, front first
        slid_pkg::out_t     pending_results[$];
        int                 n_commands;
        int                 n_inserted;
        int                 n_dropped;
        int                 n_deleted;
        int                 n_ignored;
        int                 n_checked;
        int                 n_errors;

        function int list_size();
            return held.size();
        endfunction

        // Apply one accepted command and queue the list read-out it causes.
        function void note_command(slid_pkg::in_t c);
            logic            refused;
            slid_pkg::out_t  r;
            refused = 1'b0;
            n_commands++;
            if (c.kind == slid_pkg::KIND_FRONT || c.kind == slid_pkg::KIND_BACK)
            begin
                if (held.size() >= slid_pkg::CAPACITY)
                begin
                    refused = 1'b1;
                    n_dropped++;
                end
                else
                begin
                    if (c.kind == slid_pkg::KIND_FRONT)
                        held.push_front(c.value);
                    else
                        held.push_back(c.value);
                    n_inserted++;
                end
            end
            else if (c.kind == slid_pkg::KIND_DELETE)
            begin
                if (c.position >= 0 && c.position < held.size())
                begin
                    held.delete(int'(c.position));
                    n_deleted++;
                end
                else
                begin
                    n_ignored++;
                end
            end
            else
            begin
                n_ignored++;
            end

            if (held.size() == 0)
            begin
                r.element    = '0;
                r.is_last    = 1'b1;
                r.list_empty = 1'b1;
                r.dropped    = refused;
                pending_results.push_back(r);
            end
            else
            begin
                foreach (held[i])
                begin
                    r.element    = held[i];
                    r.is_last    = (i == held.size() - 1);
                    r.list_empty = 1'b0;
                    r.dropped    = refused;
                    pending_results.push_back(r);
                end
            end
        endfunction

        // Compare one result transaction with the oldest one expected.
        function void check_result(slid_pkg::out_t got);
            slid_pkg::out_t want;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: element %0d last %0b empty %0b drop %0b",
                       got.element, got.is_last, got.list_empty, got.dropped);
                n_errors++;
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            if (got.element !== want.element)
            begin
                $error("element: expected %0d, actual %0d", want.element, got.element);
                n_errors++;
            end
            if (got.is_last !== want.is_last)
            begin
                $error("is_last: expected %0b, actual %0b", want.is_last, got.is_last);
                n_errors++;
            end
            if (got.list_empty !== want.list_empty)
            begin
                $error("list_empty: expected %0b, actual %0b",
                       want.list_empty, got.list_empty);
                n_errors++;
            end
            if (got.dropped !== want.dropped)
            begin
                $error("dropped: expected %0b, actual %0b", want.dropped, got.dropped);
                n_errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic           clk     = 1'b0;
    logic           rst_n   = 1'b0;
    logic           start   = 1'b0;
    slid_pkg::in_t  command = '0;
    logic           busy;
    logic           strobe;
    slid_pkg::out_t result;

    list_scoreboard sb = new;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sequence_list_insert_delete u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .strobe  (strobe),
        .result  (result)
    );

    // Results cannot be held off, so every strobed cycle is a transaction.
    // Sampled at the edge that closes the cycle, before the DUT updates.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check_result(result);
    end

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Called at a rising edge. Presents the command and holds start until
    // an edge sees start high with busy low; returns at that edge with
    // start still high, so a back-to-back command can follow directly.
    task automatic send_command(input slid_pkg::in_t c);
        start   <= 1'b1;
        command <= c;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(c);
    endtask

    // Drop start for a burst of idle cycles; returns at a rising edge.
    task automatic idle_for(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic slid_pkg::in_t mk(input logic [1:0] kind, input logic [31:0] value,
                                         input logic [31:0] position);
        slid_pkg::in_t c;
        c.kind     = kind;
        c.value    = value;
        c.position = position;
        return c;
    endfunction

    // Values lean on the extremes now and then, otherwise full random.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // One random command, weighted by the current phase. Around a tenth
    // is noise: unused kind or a delete position that cannot hit.
    function automatic slid_pkg::in_t random_command(input phase_t ph, input int cnt);
        int          roll;
        int          insert_pct;
        logic [31:0] pos;
        roll = $urandom_range(0, 99);
        case (ph)
            PH_GROW:   insert_pct = 85;
            PH_SHRINK: insert_pct = 15;
            default:   insert_pct = 50;
        endcase
        if (roll < 5)
            return mk(KIND_UNUSED, $urandom(), $urandom());
        if (roll < 12)
        begin
            // delete that must be ignored
            case ($urandom_range(0, 3))
                0:       pos = 32'hffff_ffff;
                1:       pos = cnt;
                2:       pos = 32'h8000_0000 | $urandom();
                default: pos = $urandom_range(cnt, 32'h7fff_ffff);
            endcase
            return mk(slid_pkg::KIND_DELETE, $urandom(), pos);
        end
        if ($urandom_range(0, 99) < insert_pct)
            return mk($urandom_range(0, 1) ? slid_pkg::KIND_FRONT : slid_pkg::KIND_BACK,
                      pick_value(), $urandom());
        // in-range delete when possible, mostly head/tail/middle mix
        pos = (cnt == 0) ? 32'd0 : $urandom_range(0, cnt - 1);
        return mk(slid_pkg::KIND_DELETE, $urandom(), pos);
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        slid_pkg::in_t directed[$];
        phase_t        ph;
        int            phase_left;
        int            drain;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, extremes, unused fields, out-of-range deletes,
        // head/middle/tail deletes, and draining back to empty.
        directed.push_back(mk(slid_pkg::KIND_DELETE, 32'h1234_5678, 32'd0));  // delete on empty
        directed.push_back(mk(KIND_UNUSED, 32'hffff_ffff, 32'hffff_ffff));    // no-op kind
        directed.push_back(mk(slid_pkg::KIND_FRONT,  32'h8000_0000, 32'd0));
        directed.push_back(mk(slid_pkg::KIND_BACK,   32'h7fff_ffff, 32'd0));
        directed.push_back(mk(slid_pkg::KIND_FRONT,  32'h0000_0000, 32'h7fff_ffff));
        directed.push_back(mk(slid_pkg::KIND_BACK,   32'hffff_ffff, 32'h8000_0000));
        directed.push_back(mk(slid_pkg::KIND_FRONT,  32'h5555_5555, 32'hffff_ffff));
        directed.push_back(mk(slid_pkg::KIND_BACK,   32'haaaa_aaaa, 32'h5555_5555));
        directed.push_back(mk(slid_pkg::KIND_DELETE, 32'd0, 32'hffff_ffff));  // negative
        directed.push_back(mk(slid_pkg::KIND_DELETE, 32'd0, 32'd6));          // equal to count
        directed.push_back(mk(slid_pkg::KIND_DELETE, 32'd0, 32'h7fff_ffff));
        directed.push_back(mk(slid_pkg::KIND_DELETE, 32'd0, 32'h8000_0000));
        directed.push_back(mk(KIND_UNUSED, 32'h0f0f_0f0f, 32'd1));
        directed.push_back(mk(slid_pkg::KIND_DELETE, 32'hffff_ffff, 32'd5));  // tail
        directed.push_back(mk(slid_pkg::KIND_DELETE, 32'h0000_0000, 32'd0));  // head
        directed.push_back(mk(slid_pkg::KIND_DELETE, 32'h5555_5555, 32'd2));  // middle
        directed.push_back(mk(slid_pkg::KIND_DELETE, 32'haaaa_aaaa, 32'd1));
        directed.push_back(mk(slid_pkg::KIND_DELETE, 32'd0, 32'd0));
        directed.push_back(mk(slid_pkg::KIND_DELETE, 32'd0, 32'd0));          // back to empty
        directed.push_back(mk(slid_pkg::KIND_BACK,   32'h0000_0001, 32'hffff_ffff));
        directed.push_back(mk(slid_pkg::KIND_DELETE, 32'd0, 32'd0));

        foreach (directed[i])
        begin
            send_command(directed[i]);
            if (i % 4 == 3)
                idle_for($urandom_range(1, 15));
        end

        // Random: phases of growth, churn and shrinkage. Growth phases are
        // long enough to hit the capacity and exercise refused inserts.
        ph = PH_GROW;
        phase_left = $urandom_range(45, 60);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       ph = PH_GROW;
                    1:       ph = PH_SHRINK;
                    default: ph = PH_MIXED;
                endcase
                phase_left = (ph == PH_GROW) ? $urandom_range(35, 50) : $urandom_range(15, 35);
            end
            phase_left--;
            send_command(random_command(ph, sb.list_size()));
            if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 99) < 30)
                idle_for($urandom_range(1, 15));
        end
        start <= 1'b0;

        // Let the last read-out arrive, then wait on before the final check.
        drain = 0;
        while (sb.pending_results.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (2 * slid_pkg::CAPACITY + 8) @(posedge clk);

        if (sb.pending_results.size() != 0)
        begin
            $error("%0d result transactions never arrived", sb.pending_results.size());
            sb.n_errors++;
        end

        $display("Covered %0d commands: %0d inserts taken, %0d refused on a full list,",
                 sb.n_commands, sb.n_inserted, sb.n_dropped);
        $display("%0d deletes taken, %0d commands ignored; %0d result transactions checked.",
                 sb.n_deleted, sb.n_ignored, sb.n_checked);
        if (sb.n_errors == 0)
            $display("sequence_list_insert_delete verification clean");
        else
            $display("sequence_list_insert_delete verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (~220 commands plus idling).
    initial
    begin
        #5_000_000;
        $display("sequence_list_insert_delete verification failed");
        $finish;
    end

endmodule
